// ===== rtl/psq_pkg.sv =====
// Package for the priority sorted task queue.
// Holds sizes, request and status codes, and the controller/datapath bundles.
// No dependencies.
package psq_pkg;

    // Queue size and derived widths.
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;
    localparam int ID_W  = 16;
    localparam int PRI_W = 8;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SORT   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       do_insert;
        logic       scan_start;
        logic       scan_step;
        logic       do_shift;
        logic       sort_start;
        logic       sort_pass;
        logic       status_we;
        logic [1:0] status;
        logic       load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       full;
        logic       hit;
        logic       scan_last;
        logic       sort_last;
    } t_dp_stat;

endpackage

// ===== rtl/psq_datapath.sv =====
// Datapath of the priority sorted task queue: slot storage, count, scan
// pointer, sort pass counter and the result register.
// Depends on psq_pkg.
module psq_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  psq_pkg::t_dp_cmd            i_cmd,
    output psq_pkg::t_dp_stat           o_stat,
    input  logic [1:0]                  i_req_type,
    input  logic [psq_pkg::ID_W-1:0]    i_entry_id,
    input  logic [psq_pkg::PRI_W-1:0]   i_entry_priority,
    output logic [1:0]                  o_status,
    output logic [psq_pkg::CNT_W-1:0]   o_entry_count,
    output logic [psq_pkg::ID_W-1:0]    o_head_id,
    output logic [psq_pkg::PRI_W-1:0]   o_head_priority
);

    // Captured request.
    logic [1:0]                r_req_type;
    logic [psq_pkg::ID_W-1:0]  r_req_id;
    logic [psq_pkg::PRI_W-1:0] r_req_pri;

    // Slot storage and bookkeeping.
    logic [psq_pkg::ID_W-1:0]  r_slot_id  [psq_pkg::DEPTH];
    logic [psq_pkg::PRI_W-1:0] r_slot_pri [psq_pkg::DEPTH];
    logic [psq_pkg::ID_W-1:0]  n_slot_id  [psq_pkg::DEPTH];
    logic [psq_pkg::PRI_W-1:0] n_slot_pri [psq_pkg::DEPTH];
    logic [psq_pkg::CNT_W-1:0] r_count;
    logic [psq_pkg::CNT_W-1:0] n_count;
    logic [psq_pkg::IDX_W-1:0] r_ptr;
    logic [psq_pkg::CNT_W-1:0] r_pass;
    logic [1:0]                r_status;

    // Result register.
    logic [1:0]                r_out_status;
    logic [psq_pkg::CNT_W-1:0] r_out_count;
    logic [psq_pkg::ID_W-1:0]  r_out_id;
    logic [psq_pkg::PRI_W-1:0] r_out_pri;

    logic [psq_pkg::CNT_W-1:0] ptr_next;
    logic [psq_pkg::CNT_W-1:0] pass_next;

    assign ptr_next  = psq_pkg::CNT_W'(r_ptr) + psq_pkg::CNT_W'(1);
    assign pass_next = r_pass + psq_pkg::CNT_W'(1);

    // Status back to the controller.
    always_comb begin
        o_stat.req_type  = r_req_type;
        o_stat.full      = (r_count >= psq_pkg::CNT_W'(psq_pkg::DEPTH));
        o_stat.hit       = (psq_pkg::CNT_W'(r_ptr) < r_count) &&
                           (r_slot_id[r_ptr] == r_req_id);
        o_stat.scan_last = (ptr_next >= r_count);
        o_stat.sort_last = (pass_next >= r_count);
    end

    // Next slot contents: append, shift toward the head, or one sort pass.
    always_comb begin
        n_slot_id  = r_slot_id;
        n_slot_pri = r_slot_pri;
        n_count    = r_count;
        if (i_cmd.do_insert) begin
            n_slot_id[r_count[psq_pkg::IDX_W-1:0]]  = r_req_id;
            n_slot_pri[r_count[psq_pkg::IDX_W-1:0]] = r_req_pri;
            n_count = r_count + psq_pkg::CNT_W'(1);
        end else if (i_cmd.do_shift) begin
            for (int k = 0; k < psq_pkg::DEPTH - 1; k++) begin
                if (psq_pkg::IDX_W'(k) >= r_ptr) begin
                    n_slot_id[k]  = r_slot_id[k+1];
                    n_slot_pri[k] = r_slot_pri[k+1];
                end
            end
            n_count = r_count - psq_pkg::CNT_W'(1);
        end else if (i_cmd.sort_pass) begin
            // Odd-even transposition: disjoint neighbor pairs of one parity.
            for (int j = 0; j < psq_pkg::DEPTH - 1; j++) begin
                if (((j % 2) == int'(r_pass[0])) &&
                    (psq_pkg::CNT_W'(j + 1) < r_count) &&
                    (r_slot_pri[j] < r_slot_pri[j+1])) begin
                    n_slot_id[j]    = r_slot_id[j+1];
                    n_slot_pri[j]   = r_slot_pri[j+1];
                    n_slot_id[j+1]  = r_slot_id[j];
                    n_slot_pri[j+1] = r_slot_pri[j];
                end
            end
        end
    end

    // Slot storage carries no reset.
    always_ff @(posedge i_clk) begin
        r_slot_id  <= n_slot_id;
        r_slot_pri <= n_slot_pri;
    end

    // Count is control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Request capture, scan pointer, pass counter, status and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_req_id   <= i_entry_id;
            r_req_pri  <= i_entry_priority;
        end
        if (i_cmd.scan_start) begin
            r_ptr <= '0;
        end else if (i_cmd.scan_step) begin
            r_ptr <= r_ptr + psq_pkg::IDX_W'(1);
        end
        if (i_cmd.sort_start) begin
            r_pass <= '0;
        end else if (i_cmd.sort_pass) begin
            r_pass <= pass_next;
        end
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_id     <= (r_count != '0) ? r_slot_id[0]  : '0;
            r_out_pri    <= (r_count != '0) ? r_slot_pri[0] : '0;
        end
    end

    assign o_status        = r_out_status;
    assign o_entry_count   = r_out_count;
    assign o_head_id       = r_out_id;
    assign o_head_priority = r_out_pri;

endmodule

// ===== rtl/psq_control.sv =====
// Controller of the priority sorted task queue: sequences insert, remove
// and sort, and owns the input and output handshakes.
// Depends on psq_pkg.
module psq_control (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  psq_pkg::t_dp_stat  i_stat,
    output psq_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_SHIFT,
        S_SORT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // Next state, commands and result valid.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.status_we = 1'b1;
                o_cmd.status    = psq_pkg::ST_DONE;
                unique case (i_stat.req_type)
                    psq_pkg::REQ_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.status = psq_pkg::ST_FULL;
                        end else begin
                            o_cmd.do_insert = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    psq_pkg::REQ_REMOVE: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SEARCH;
                    end
                    psq_pkg::REQ_SORT: begin
                        o_cmd.sort_start = 1'b1;
                        n_state          = S_SORT;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SEARCH: begin
                if (i_stat.hit) begin
                    n_state = S_SHIFT;
                end else if (i_stat.scan_last) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = psq_pkg::ST_NOT_FOUND;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.do_shift = 1'b1;
                n_state        = S_DONE;
            end
            S_SORT: begin
                o_cmd.sort_pass = 1'b1;
                if (i_stat.sort_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/priority_sorted_task_queue.sv =====
// Priority sorted task queue: a 16-entry queue of (id, priority) words.
// Top level; instantiates psq_control and psq_datapath, uses psq_pkg.
//
// Usage: a request word (i_req_type, i_entry_id, i_entry_priority) is taken
// when i_in_valid is high and o_in_stall is low. Insert appends at the tail
// or reports full; remove deletes the first entry with the id and closes
// the gap, or reports not found; sort orders the entries by descending
// priority, keeping the order of equal priorities. Every request yields
// one result word: status, entry count and the head entry (zero if empty),
// offered on o_out_valid and taken when i_out_stall is low.
// The remove scan steps one slot per cycle and the sort runs one odd-even
// transposition pass per cycle.
// One request is worked on at a time; a new one is taken as soon as the
// previous result is in the output register, even if that is stalled.
// A finished result waits while the output register is still held.
// Reset (synchronous, active low) empties the queue and drops any result.
module priority_sorted_task_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [psq_pkg::ID_W-1:0]    i_entry_id,
    input  logic [psq_pkg::PRI_W-1:0]   i_entry_priority,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic [psq_pkg::CNT_W-1:0]   o_entry_count,
    output logic [psq_pkg::ID_W-1:0]    o_head_id,
    output logic [psq_pkg::PRI_W-1:0]   o_head_priority
);

    psq_pkg::t_dp_cmd  cmd;
    psq_pkg::t_dp_stat stat;

    // Sequencer.
    psq_control u_control (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Storage and result register.
    psq_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req_type),
        .i_entry_id       (i_entry_id),
        .i_entry_priority (i_entry_priority),
        .o_status         (o_status),
        .o_entry_count    (o_entry_count),
        .o_head_id        (o_head_id),
        .o_head_priority  (o_head_priority)
    );

endmodule

// ===== test/priority_sorted_task_queue_test.sv =====
// Self-checking testbench for the priority sorted task queue.
// Drives a directed table and then random request words, and checks each result word.
// Depends on psq_pkg and on the priority_sorted_task_queue RTL.
module priority_sorted_task_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Code 3 has no meaning to the block and must leave the queue untouched.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 1500;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        logic [1:0]                status;
        logic [psq_pkg::CNT_W-1:0] count;
        logic [psq_pkg::ID_W-1:0]  head_id;
        logic [psq_pkg::PRI_W-1:0] head_pri;
    } t_result;

    typedef struct {
        logic [1:0]                req;
        logic [psq_pkg::ID_W-1:0]  id;
        logic [psq_pkg::PRI_W-1:0] pri;
        bit                        known;
        t_result                   want;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_req_type = 2'd0;
    logic [psq_pkg::ID_W-1:0]  i_entry_id = '0;
    logic [psq_pkg::PRI_W-1:0] i_entry_priority = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [1:0]                o_status;
    logic [psq_pkg::CNT_W-1:0] o_entry_count;
    logic [psq_pkg::ID_W-1:0]  o_head_id;
    logic [psq_pkg::PRI_W-1:0] o_head_priority;

    // Predicted queue contents, slot 0 is the head.
    logic [psq_pkg::ID_W-1:0]  held_ids [psq_pkg::DEPTH];
    logic [psq_pkg::PRI_W-1:0] held_pris [psq_pkg::DEPTH];
    int                        held_count = 0;

    t_result awaited_results [$];

    int send_gap_pct  = 0;
    int out_stall_pct = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int n_insert = 0, n_remove = 0, n_sort = 0, n_unused = 0;
    int n_full = 0, n_not_found = 0, peak_count = 0;

    priority_sorted_task_queue u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_entry_id       (i_entry_id),
        .i_entry_priority (i_entry_priority),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_entry_count    (o_entry_count),
        .o_head_id        (o_head_id),
        .o_head_priority  (o_head_priority)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side: random stall at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Apply one request to the predicted queue and return the result word it yields.
    function automatic t_result predict_request(logic [1:0] req,
                                                logic [psq_pkg::ID_W-1:0] id,
                                                logic [psq_pkg::PRI_W-1:0] pri);
        t_result                   r;
        int                        pos;
        logic [psq_pkg::ID_W-1:0]  tid;
        logic [psq_pkg::PRI_W-1:0] tpri;
        r.status = psq_pkg::ST_DONE;
        case (req)
            psq_pkg::REQ_INSERT: begin
                n_insert++;
                if (held_count >= psq_pkg::DEPTH) begin
                    r.status = psq_pkg::ST_FULL;
                    n_full++;
                end else begin
                    held_ids[held_count]  = id;
                    held_pris[held_count] = pri;
                    held_count++;
                end
            end
            psq_pkg::REQ_REMOVE: begin
                n_remove++;
                pos = -1;
                for (int k = 0; k < held_count; k++) begin
                    if (pos < 0 && held_ids[k] == id) pos = k;
                end
                if (pos < 0) begin
                    r.status = psq_pkg::ST_NOT_FOUND;
                    n_not_found++;
                end else begin
                    for (int k = pos; k < held_count - 1; k++) begin
                        held_ids[k]  = held_ids[k + 1];
                        held_pris[k] = held_pris[k + 1];
                    end
                    held_count--;
                end
            end
            psq_pkg::REQ_SORT: begin
                n_sort++;
                // Stable: neighbors swap only on a strictly lower left priority.
                for (int p = 0; p + 1 < held_count; p++) begin
                    for (int j = 0; j + 1 < held_count; j++) begin
                        if (held_pris[j] < held_pris[j + 1]) begin
                            tid  = held_ids[j];
                            tpri = held_pris[j];
                            held_ids[j]      = held_ids[j + 1];
                            held_pris[j]     = held_pris[j + 1];
                            held_ids[j + 1]  = tid;
                            held_pris[j + 1] = tpri;
                        end
                    end
                end
            end
            default: n_unused++;
        endcase
        if (held_count > peak_count) peak_count = held_count;
        r.count    = psq_pkg::CNT_W'(held_count);
        r.head_id  = (held_count > 0) ? held_ids[0] : '0;
        r.head_pri = (held_count > 0) ? held_pris[0] : '0;
        return r;
    endfunction

    function automatic t_row stim(logic [1:0] req, logic [psq_pkg::ID_W-1:0] id,
                                  logic [psq_pkg::PRI_W-1:0] pri);
        t_row row;
        row.req   = req;
        row.id    = id;
        row.pri   = pri;
        row.known = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic t_row stim_known(logic [1:0] req, logic [psq_pkg::ID_W-1:0] id,
                                        logic [psq_pkg::PRI_W-1:0] pri, logic [1:0] st,
                                        int cnt, logic [psq_pkg::ID_W-1:0] hid,
                                        logic [psq_pkg::PRI_W-1:0] hpri);
        t_row row;
        row = stim(req, id, pri);
        row.known         = 1'b1;
        row.want.status   = st;
        row.want.count    = psq_pkg::CNT_W'(cnt);
        row.want.head_id  = hid;
        row.want.head_pri = hpri;
        return row;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Present one request word, wait for it to be taken, and record what it should yield.
    task automatic issue_request(t_row row);
        t_result predicted;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= row.req;
        i_entry_id       <= row.id;
        i_entry_priority <= row.pri;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = predict_request(row.req, row.id, row.pri);
        awaited_results.push_back(row.known ? row.want : predicted);
    endtask

    // Lower valid and hold off until every awaited result word has come back.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Random request word; inserts dominate while filling, removes while draining.
    function automatic t_row pick_random_request(bit filling);
        int                        sel;
        int                        ins_w;
        int                        rem_w;
        logic [psq_pkg::ID_W-1:0]  id;
        logic [psq_pkg::PRI_W-1:0] pri;
        ins_w = filling ? 65 : 25;
        rem_w = filling ? 15 : 50;
        sel   = $urandom_range(0, 99);
        // A small id pool makes duplicate ids, so first-match removal gets exercised.
        id    = ($urandom_range(0, 1) == 0) ? psq_pkg::ID_W'($urandom_range(0, 7))
                                            : psq_pkg::ID_W'($urandom);
        case ($urandom_range(0, 9))
            0:       pri = '0;
            1:       pri = '1;
            2, 3, 4: pri = psq_pkg::PRI_W'($urandom_range(0, 3));
            default: pri = psq_pkg::PRI_W'($urandom);
        endcase
        if (sel < ins_w) return stim(psq_pkg::REQ_INSERT, id, pri);
        if (sel < ins_w + rem_w) begin
            if (held_count > 0 && $urandom_range(0, 99) < 80)
                id = held_ids[$urandom_range(0, held_count - 1)];
            return stim(psq_pkg::REQ_REMOVE, id, pri);
        end
        if (sel < 96) return stim(psq_pkg::REQ_SORT, id, pri);
        return stim(REQ_UNUSED, id, pri);
    endfunction

    // Result side: compare every accepted result word with the oldest awaited one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result word with none awaited (status %0d)",
                                          o_status));
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                if (o_entry_count !== want.count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              o_entry_count, want.count));
                if (o_head_id !== want.head_id)
                    report_mismatch($sformatf("head_id %h, expected %h",
                                              o_head_id, want.head_id));
                if (o_head_priority !== want.head_pri)
                    report_mismatch($sformatf("head_priority %h, expected %h",
                                              o_head_priority, want.head_pri));
            end
        end
    end

    // Watchdog: ends the run when neither side moves a word for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d results still awaited",
                 STALL_LIMIT, awaited_results.size());
        $display("[priority_sorted_task_queue] ERROR");
        $finish;
    end

    initial begin
        t_row rows [$];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: empty-queue cases, extremes of id and priority, a full
        // queue with equal priorities, a drop on full, and misses on remove.
        rows.push_back(stim_known(psq_pkg::REQ_REMOVE, 16'h0000, 8'h00,
                                  psq_pkg::ST_NOT_FOUND, 0, 16'h0, 8'h0));
        rows.push_back(stim_known(psq_pkg::REQ_SORT, 16'h0000, 8'h00,
                                  psq_pkg::ST_DONE, 0, 16'h0, 8'h0));
        rows.push_back(stim_known(REQ_UNUSED, 16'hFFFF, 8'hFF,
                                  psq_pkg::ST_DONE, 0, 16'h0, 8'h0));
        rows.push_back(stim_known(psq_pkg::REQ_INSERT, 16'hFFFF, 8'h00,
                                  psq_pkg::ST_DONE, 1, 16'hFFFF, 8'h00));
        rows.push_back(stim_known(psq_pkg::REQ_SORT, 16'h0000, 8'h00,
                                  psq_pkg::ST_DONE, 1, 16'hFFFF, 8'h00));
        rows.push_back(stim_known(psq_pkg::REQ_INSERT, 16'h0000, 8'hFF,
                                  psq_pkg::ST_DONE, 2, 16'hFFFF, 8'h00));
        rows.push_back(stim_known(psq_pkg::REQ_SORT, 16'h0000, 8'h00,
                                  psq_pkg::ST_DONE, 2, 16'h0000, 8'hFF));
        for (int k = 0; k < 14; k++)
            rows.push_back(stim(psq_pkg::REQ_INSERT, 16'h0100 + 16'(k), 8'((k % 4) * 64)));
        rows.push_back(stim_known(psq_pkg::REQ_INSERT, 16'hBEEF, 8'h55,
                                  psq_pkg::ST_FULL, 16, 16'h0000, 8'hFF));
        rows.push_back(stim(psq_pkg::REQ_SORT, 16'h0000, 8'h00));
        rows.push_back(stim_known(psq_pkg::REQ_REMOVE, 16'h1234, 8'h00,
                                  psq_pkg::ST_NOT_FOUND, 16, 16'h0000, 8'hFF));
        rows.push_back(stim(psq_pkg::REQ_REMOVE, 16'h0000, 8'h00));

        foreach (rows[r]) issue_request(rows[r]);
        hold_until_drained();

        // Random part in four phases of differing send gaps and output stalls, pausing for a full drain between them.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_gap_pct = 0;  out_stall_pct = 0;  end
                1:       begin send_gap_pct = 52; out_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  out_stall_pct = 52; end
                default: begin send_gap_pct = 22; out_stall_pct = 22; end
            endcase
            for (int i = 0; i < RANDOM_WORDS / 4; i++)
                issue_request(pick_random_request(((i / 48) % 2) == 0));
            hold_until_drained();
        end

        // Quiet tail: any stray result word is still caught by the checker.
        out_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d inserts, %0d removes, %0d sorts, %0d unused codes",
                 n_insert, n_remove, n_sort, n_unused);
        $display("%0d dropped on full, %0d removes missed, peak count %0d, %0d results checked",
                 n_full, n_not_found, peak_count, results_seen);
        if (mismatches == 0)
            $display("[priority_sorted_task_queue] OK");
        else
            $display("[priority_sorted_task_queue] ERROR");
        $finish;
    end

endmodule
